[hw/rtl/iirdf1_pkg.sv]
// ----------------------------------------------------------------------------
// IIR direct form I filter package
// Shared constants, command codes and the control and status records that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

	localparam int FILTER_ORDER = 3;
	localparam int HIST_LEN     = FILTER_ORDER + 1;
	localparam int HIST_W       = $clog2(HIST_LEN);
	localparam int NUM_COEFFS   = 4;
	localparam int COEFF_IDX_W  = $clog2(NUM_COEFFS);
	localparam int DATA_W       = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int LAST_TAP     = 2 * FILTER_ORDER;
	localparam int TAP_W        = $clog2(LAST_TAP + 1);
	localparam int DIV_STEPS    = DATA_W;
	localparam int CNT_W        = $clog2(DIV_STEPS);
	localparam int PROD_W       = 2 * DATA_W;
	localparam int ACC_W        = PROD_W + 4;
	localparam int HI_W         = ACC_W - DATA_W;

	localparam logic [CFG_IDX_W-1:0] REG_DEN_BASE = CFG_IDX_W'(NUM_COEFFS);

	localparam logic signed [DATA_W-1:0] COEFF_ONE = 32'sd65536;
	localparam logic signed [DATA_W-1:0] SAT_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN   = 32'sh8000_0000;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_SET    = 2'd1,
		CMD_SHIFT  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ABS,
		ST_CHECK,
		ST_DIV,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic             load;
		logic             acc_clr;
		logic             mul_en;
		logic [TAP_W-1:0] tap;
		logic             take_abs;
		logic             check;
		logic             div_step;
		logic             commit;
		cmd_t             op;
	} dp_ctrl_t;

	typedef struct packed {
		logic slot_free;
	} dp_status_t;

endpackage

[hw/rtl/iirdf1_ctrl.sv]
// ----------------------------------------------------------------------------
// IIR direct form I filter controller
// Sequences accept, multiply-accumulate over the taps, magnitude and range
// check, the restoring division and the final history update.
// ----------------------------------------------------------------------------
module iirdf1_ctrl import iirdf1_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       cmd,
	input  dp_status_t       status,
	output dp_ctrl_t         ctrl
);

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	cmd_t             op_q, op_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			op_q    <= CMD_NOP;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			op_q    <= op_nxt;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		cnt_nxt       = cnt_q;
		op_nxt        = op_q;
		in_stall      = 1'b1;
		ctrl          = '0;
		ctrl.op       = op_q;
		ctrl.tap      = cnt_q[TAP_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ctrl.op  = cmd_t'(cmd);
				if (in_valid) begin
					ctrl.load    = 1'b1;
					ctrl.acc_clr = 1'b1;
					op_nxt       = cmd_t'(cmd);
					cnt_nxt      = '0;
					state_nxt    = (cmd_t'(cmd) == CMD_SAMPLE) ? ST_MAC : ST_COMMIT;
				end
			end
			ST_MAC: begin
				ctrl.mul_en = 1'b1;
				if (cnt_q == CNT_W'(LAST_TAP)) begin
					cnt_nxt   = '0;
					state_nxt = ST_DRAIN;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_ABS;
			end
			ST_ABS: begin
				ctrl.take_abs = 1'b1;
				state_nxt     = ST_CHECK;
			end
			ST_CHECK: begin
				ctrl.check = 1'b1;
				cnt_nxt    = '0;
				state_nxt  = ST_DIV;
			end
			ST_DIV: begin
				ctrl.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					cnt_nxt   = '0;
					state_nxt = ST_COMMIT;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			ST_COMMIT: begin
				if (status.slot_free) begin
					ctrl.commit = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/iirdf1_dp.sv]
// ----------------------------------------------------------------------------
// IIR direct form I filter datapath
// Coefficient registers, input and output histories, one shared multiplier
// with a wide accumulator, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module iirdf1_dp import iirdf1_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic signed [DATA_W-1:0] value,
	input  dp_ctrl_t                 ctrl,
	output dp_status_t               status,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] filtered,
	output logic                     fault
);

	logic signed [DATA_W-1:0] num_q [NUM_COEFFS];
	logic signed [DATA_W-1:0] den_q [NUM_COEFFS];
	logic signed [DATA_W-1:0] x_q [HIST_LEN];
	logic signed [DATA_W-1:0] y_q [HIST_LEN];
	logic signed [DATA_W-1:0] value_q;

	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic                     mul_sub;
	logic [TAP_W-1:0]         den_tap, y_tap;
	logic signed [PROD_W-1:0] prod_q;
	logic                     prod_sub_q;
	logic                     prod_vld_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;

	logic [ACC_W-1:0]  mag_q;
	logic              neg_q, zero_q, qneg_q, dzero_q, ovf_q;
	logic [DATA_W-1:0] d_q, rem_q, dvd_q;
	logic [DATA_W:0]   trial;
	logic              trial_ge;

	logic signed [DATA_W-1:0] y_new;
	logic                     y_fault;
	logic signed [DATA_W-1:0] x_nxt [HIST_LEN];
	logic signed [DATA_W-1:0] y_nxt [HIST_LEN];
	logic                     fault_nxt;
	logic [DATA_W:0]          sum_x [HIST_LEN];
	logic [DATA_W:0]          sum_y [HIST_LEN];
	logic                     out_valid_q;

	function automatic logic [DATA_W:0] sat_add(input logic signed [DATA_W-1:0] a,
	                                            input logic signed [DATA_W-1:0] b);
		logic signed [DATA_W:0] s;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1]) begin
			return {1'b1, s[DATA_W] ? SAT_MIN : SAT_MAX};
		end
		return {1'b0, s[DATA_W-1:0]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFFS; i++) begin
				num_q[i] <= '0;
				den_q[i] <= '0;
			end
			num_q[0] <= COEFF_ONE;
			den_q[0] <= COEFF_ONE;
		end else if (cfg_wr_en) begin
			if (cfg_index < REG_DEN_BASE) begin
				num_q[cfg_index[COEFF_IDX_W-1:0]] <= cfg_data;
			end else begin
				den_q[cfg_index[COEFF_IDX_W-1:0]] <= cfg_data;
			end
		end
	end

	assign den_tap = ctrl.tap - TAP_W'(FILTER_ORDER);
	assign y_tap   = den_tap - 1'b1;

	always_comb begin
		if (ctrl.tap <= TAP_W'(FILTER_ORDER)) begin
			mul_a   = num_q[ctrl.tap[COEFF_IDX_W-1:0]];
			mul_b   = x_q[ctrl.tap[HIST_W-1:0]];
			mul_sub = 1'b0;
		end else begin
			mul_a   = den_q[den_tap[COEFF_IDX_W-1:0]];
			mul_b   = y_q[y_tap[HIST_W-1:0]];
			mul_sub = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q     <= PROD_W'(mul_a) * PROD_W'(mul_b);
			prod_sub_q <= mul_sub;
		end
	end

	assign prod_ext = ACC_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_q <= 1'b0;
		end else begin
			prod_vld_q <= ctrl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (prod_vld_q) begin
			acc_q <= prod_sub_q ? acc_q - prod_ext : acc_q + prod_ext;
		end
	end

	assign trial    = {rem_q, dvd_q[DATA_W-1]};
	assign trial_ge = trial >= {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (ctrl.take_abs) begin
			mag_q   <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
			neg_q   <= acc_q[ACC_W-1];
			zero_q  <= (acc_q == '0);
			d_q     <= den_q[0][DATA_W-1] ? DATA_W'(-den_q[0]) : DATA_W'(den_q[0]);
			qneg_q  <= acc_q[ACC_W-1] ^ den_q[0][DATA_W-1];
			dzero_q <= (den_q[0] == '0);
		end
		if (ctrl.check) begin
			ovf_q <= mag_q[ACC_W-1:DATA_W] >= HI_W'(d_q);
			rem_q <= mag_q[2*DATA_W-1:DATA_W];
			dvd_q <= mag_q[DATA_W-1:0];
		end else if (ctrl.div_step) begin
			rem_q <= trial_ge ? DATA_W'(trial - {1'b0, d_q}) : trial[DATA_W-1:0];
			dvd_q <= {dvd_q[DATA_W-2:0], trial_ge};
		end
	end

	always_comb begin
		y_fault = 1'b1;
		if (dzero_q) begin
			y_new = zero_q ? '0 : (neg_q ? SAT_MIN : SAT_MAX);
		end else if (ovf_q) begin
			y_new = qneg_q ? SAT_MIN : SAT_MAX;
		end else if (qneg_q) begin
			if (dvd_q > DATA_W'(SAT_MIN)) begin
				y_new = SAT_MIN;
			end else begin
				y_new   = -dvd_q;
				y_fault = 1'b0;
			end
		end else if (dvd_q[DATA_W-1]) begin
			y_new = SAT_MAX;
		end else begin
			y_new   = dvd_q;
			y_fault = 1'b0;
		end
	end

	always_comb begin
		fault_nxt = 1'b0;
		for (int i = 0; i < HIST_LEN; i++) begin
			x_nxt[i] = x_q[i];
			y_nxt[i] = y_q[i];
			sum_x[i] = sat_add(x_q[i], value_q);
			sum_y[i] = sat_add(y_q[i], value_q);
		end
		case (ctrl.op)
			CMD_SAMPLE: begin
				for (int i = HIST_LEN - 1; i > 0; i--) begin
					y_nxt[i] = y_q[i-1];
				end
				y_nxt[0]  = y_new;
				fault_nxt = y_fault;
			end
			CMD_SET: begin
				for (int i = 0; i < HIST_LEN; i++) begin
					x_nxt[i] = value_q;
					y_nxt[i] = value_q;
				end
			end
			CMD_SHIFT: begin
				for (int i = 0; i < HIST_LEN; i++) begin
					x_nxt[i]  = sum_x[i][DATA_W-1:0];
					y_nxt[i]  = sum_y[i][DATA_W-1:0];
					fault_nxt = fault_nxt | sum_x[i][DATA_W] | sum_y[i][DATA_W];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++) begin
				x_q[i] <= '0;
				y_q[i] <= '0;
			end
		end else if (ctrl.load && ctrl.op == CMD_SAMPLE) begin
			for (int i = HIST_LEN - 1; i > 0; i--) begin
				x_q[i] <= x_q[i-1];
			end
			x_q[0] <= value;
		end else if (ctrl.commit) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= value;
		end
		if (ctrl.commit) begin
			filtered <= y_nxt[0];
			fault    <= fault_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.slot_free = !out_valid_q || !out_stall;

endmodule

[hw/rtl/iir_direct_form_one_filter.sv]
// ----------------------------------------------------------------------------
// IIR direct form I filter, order 3, signed Q16.16
// Top level: joins the controller and the datapath.
// ----------------------------------------------------------------------------
// A sample item passes through the accept step, multiply-accumulate over
// seven taps through the single shared 32 by 32 multiplier, a step to drain
// the product register, the magnitude and range check steps, 32 steps of
// the one-bit-per-cycle restoring divider by a0, and the commit step, which
// waits while the previous result is still held and not taken. Set-to,
// shift-by and no-operation items go from accept straight to commit. One item
// is in flight at a time; a new item is accepted as soon as the previous one
// has reached the output register, even if that result has not yet been
// taken. Coefficients may be written only while no item is in flight.
module iir_direct_form_one_filter import iirdf1_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               cmd,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] filtered,
	output logic                     fault
);

	dp_ctrl_t   ctrl;
	dp_status_t status;

	iirdf1_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status),
		.ctrl     (ctrl)
	);

	iirdf1_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.value     (value),
		.ctrl      (ctrl),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.filtered  (filtered),
		.fault     (fault)
	);

endmodule
